// ----- design/gmps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmps_pkg
// shared widths, types and helpers of the grid max path block
// ----------------------------------------------------------------------------
package gmps_pkg;

  localparam int unsigned MAX_ROWS   = 512;
  localparam int unsigned MAX_COLS   = 512;
  localparam int unsigned SKIP_LIMIT = 2;
  localparam int unsigned LAYERS     = SKIP_LIMIT + 1;

  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned TOTAL_W   = 26;
  localparam int unsigned CNT_W     = 10;
  localparam int unsigned ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = CFG_IDX_W'(1);

  localparam logic signed [TOTAL_W:0] TOTAL_MAX = (TOTAL_W + 1)'((1 << (TOTAL_W - 1)) - 1);
  localparam logic signed [TOTAL_W:0] TOTAL_MIN = -(TOTAL_W + 1)'(1 << (TOTAL_W - 1));

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic signed [TOTAL_W-1:0] total_t;
  typedef logic signed [TOTAL_W:0]   wide_t;
  typedef total_t [LAYERS-1:0]       trio_t;

  // where the cell sits, steers which neighbors feed it
  typedef struct packed {
    logic first_row;
    logic first_col;
  } pos_t;

  // clamp a grown sum into the stored total range
  function automatic total_t sat_total(input wide_t x);
    if (x > TOTAL_MAX) begin
      return TOTAL_MAX[TOTAL_W-1:0];
    end else if (x < TOTAL_MIN) begin
      return TOTAL_MIN[TOTAL_W-1:0];
    end
    return x[TOTAL_W-1:0];
  endfunction

  // zero acts as one, anything above the cap acts as the cap
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] cap);
    if (v == '0) begin
      return CNT_W'(1);
    end else if (v > cap) begin
      return cap;
    end
    return v;
  endfunction

endpackage

// ----- design/gmps_cell_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmps_cell_update
// per-cell recurrence: best totals for each skip budget and their maximum
// ----------------------------------------------------------------------------
module gmps_cell_update (
  input  gmps_pkg::value_t cell_value_i,
  input  gmps_pkg::trio_t  above_i,
  input  gmps_pkg::trio_t  left_i,
  input  gmps_pkg::pos_t   pos_i,
  output gmps_pkg::trio_t  cur_o,
  output gmps_pkg::total_t best_o
);
  import gmps_pkg::*;

  trio_t prev;

  // best predecessor per layer
  always_comb begin
    for (int s = 0; s < LAYERS; s++) begin
      if (pos_i.first_row && pos_i.first_col) begin
        prev[s] = '0;
      end else if (pos_i.first_row) begin
        prev[s] = left_i[s];
      end else if (pos_i.first_col) begin
        prev[s] = above_i[s];
      end else begin
        prev[s] = (above_i[s] > left_i[s]) ? above_i[s] : left_i[s];
      end
    end
  end

  // take the cell, or neutralize it by spending one skip
  always_comb begin
    wide_t t;
    wide_t skip;
    for (int s = 0; s < LAYERS; s++) begin
      skip = '0;
      t = wide_t'(prev[s]) + wide_t'(cell_value_i);
      if (s > 0 && cell_value_i < 0) begin
        skip = wide_t'(prev[s-1]);
        if (skip > t) t = skip;
      end
      cur_o[s] = sat_total(t);
    end
  end

  always_comb begin
    best_o = cur_o[0];
    for (int s = 1; s < LAYERS; s++) begin
      if (cur_o[s] > best_o) best_o = cur_o[s];
    end
  end

endmodule

// ----- design/grid_max_path_with_skips.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_max_path_with_skips
// best right/down path total over a streamed grid, with up to two negative
// cells neutralized
// ----------------------------------------------------------------------------
// usage
//   cfg channel: write row_count (index 0) or col_count (index 1) while idle;
//     cfg_ready_o is always high, every write to index 0 or 1 restarts the grid at top-left
//   in channel: one cell value per item, row-major, valid/stall handshake
//   out channel: one best_total item after the last cell of every grid
// throughput
//   one item per cycle while in_stall_o is low; each cell reads one row-store entry
//   that is fetched at accept time and written back at commit, single-column grids
//   take the value from the left-neighbor registers instead
// result
//   the last cell waits in the commit stage; the result enters the output register
//   at that cell's commit edge, held back only while an earlier result waits
// reset
//   sizes return to 1x1, position to the top-left cell, no items in flight;
//   the row store is not cleared, the first row never reads it
// stall
//   a waiting result holds the output register; further cells keep flowing
//   until the next grid's last cell reaches the commit stage, then in_stall_o
//   rises until the result is taken
// ----------------------------------------------------------------------------
module grid_max_path_with_skips (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gmps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gmps_pkg::CNT_W-1:0]       cfg_data_i,
  // cell items
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  gmps_pkg::value_t                 cell_value_i,
  // result items
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output gmps_pkg::total_t                 best_total_o
);
  import gmps_pkg::*;

  // configuration registers
  logic [CNT_W-1:0] row_count_q, col_count_q;
  logic [CNT_W-1:0] rows_eff, cols_eff;

  // position of the next cell to be accepted
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic             col_end, row_end;

  // commit stage: accepted cell waiting to be folded into the row
  logic             s1_valid_q;
  value_t           s1_value_q;
  pos_t             s1_pos_q;
  logic             s1_last_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_fwd_q;
  logic             s1_adv;

  // row store and left neighbor
  trio_t            row_mem [MAX_COLS];
  trio_t            rd_q;
  trio_t            left_q;
  trio_t            above;
  trio_t            cur;
  total_t           best;

  // output register
  logic             out_valid_q;
  total_t           best_total_q;

  logic             in_acc;
  logic             cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  assign rows_eff = eff_count(row_count_q, CNT_W'(MAX_ROWS));
  assign cols_eff = eff_count(col_count_q, CNT_W'(MAX_COLS));

  assign col_end = (CNT_W'(col_q) == cols_eff - CNT_W'(1));
  assign row_end = (CNT_W'(row_q) == rows_eff - CNT_W'(1));

  // a non-final cell never needs the output register
  assign s1_adv     = s1_valid_q && (!s1_last_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // next position
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (in_acc) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= CNT_W'(1);
      col_count_q <= CNT_W'(1);
      row_q       <= '0;
      col_q       <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        CFG_ROW_COUNT: begin
          row_count_q <= cfg_data_i;
          row_q       <= '0;
          col_q       <= '0;
        end
        CFG_COL_COUNT: begin
          col_count_q <= cfg_data_i;
          row_q       <= '0;
          col_q       <= '0;
        end
        default: begin
          row_q <= row_d;
          col_q <= col_d;
        end
      endcase
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // commit stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // commit stage payload; same column twice in a row means a single-column
  // grid, then the entry being written now is taken from the left registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_value_q         <= cell_value_i;
      s1_pos_q.first_row <= (row_q == '0);
      s1_pos_q.first_col <= (col_q == '0);
      s1_last_q          <= col_end && row_end;
      s1_col_q           <= col_q;
      s1_fwd_q           <= s1_adv && (col_q == s1_col_q);
    end
  end

  // row store: read at accept, write at commit
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      row_mem[s1_col_q] <= cur;
    end
    if (in_acc) begin
      rd_q <= row_mem[col_q];
    end
  end

  assign above = s1_fwd_q ? left_q : rd_q;

  gmps_cell_update u_cell_update (
    .cell_value_i (s1_value_q),
    .above_i      (above),
    .left_i       (left_q),
    .pos_i        (s1_pos_q),
    .cur_o        (cur),
    .best_o       (best)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (s1_adv) begin
      left_q <= cur;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      best_total_q <= best;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign best_total_o = best_total_q;

`ifndef SYNTHESIS
  // stalling the input only ever comes from a blocked commit stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_last_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked final cell");

  // forwarding from the left registers only in single-column grids
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_fwd_q && !s1_pos_q.first_row) |-> (cols_eff == CNT_W'(1)))
    else $error("row store forwarding in a multi-column grid");

  // a committed final cell always lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> (out_valid_q && best_total_q == $past(best)))
    else $error("final cell did not produce a result");

  // the position never leaves the configured grid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNT_W'(col_q) < cols_eff) && (CNT_W'(row_q) < rows_eff))
    else $error("grid position out of range");
`endif

endmodule
